### design/ofsp_pkg.sv
// Shared types and constants for the object file section parser.
package ofsp_pkg;

	typedef enum logic [6:0] {
		PH_HDR0 = 7'b0000001,
		PH_HDR1 = 7'b0000010,
		PH_ADR0 = 7'b0000100,
		PH_ADR1 = 7'b0001000,
		PH_LENH = 7'b0010000,
		PH_LENL = 7'b0100000,
		PH_BODY = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SYM  = 2'd0,
		KIND_CODE = 2'd1,
		KIND_DATA = 2'd2,
		KIND_UNK  = 2'd3
	} section_kind_t;

	typedef enum logic [1:0] {
		EV_SYMBOL_CHAR  = 2'd0,
		EV_EMPTY_SYMBOL = 2'd1,
		EV_UNKNOWN_HDR  = 2'd2,
		EV_SUMMARY      = 2'd3
	} event_kind_t;

	localparam logic [7:0] HDR_SYM_0  = 8'hC3;
	localparam logic [7:0] HDR_SYM_1  = 8'hB7;
	localparam logic [7:0] HDR_CODE_0 = 8'hCA;
	localparam logic [7:0] HDR_CODE_1 = 8'hDE;
	localparam logic [7:0] HDR_DATA_0 = 8'hDA;
	localparam logic [7:0] HDR_DATA_1 = 8'hDA;

	localparam int REM_WIDTH = 17;

	typedef struct packed {
		logic          emit;
		event_kind_t   kind;
		logic [7:0]    ch;
		logic          last;
	} event_t;

	typedef struct packed {
		logic          inc;
		section_kind_t kind;
		logic          clear;
	} count_req_t;

endpackage

### design/ofsp_parse.sv
// Section phase tracker: decodes headers and lengths and raises events.
module ofsp_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                end_of_stream,
	output ofsp_pkg::event_t     ev,
	output ofsp_pkg::count_req_t creq
);
	import ofsp_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [7:0]             first_q, first_d;
	section_kind_t          kind_q, kind_d;
	logic [7:0]             lenh_q, lenh_d;
	logic [REM_WIDTH-1:0]   rem_q, rem_d;
	logic [15:0]            n;
	logic [REM_WIDTH-1:0]   rem_dec;

	assign n       = {lenh_q, data_byte};
	assign rem_dec = rem_q - REM_WIDTH'(rem_q != '0);

	always_comb begin
		phase_d    = phase_q;
		first_d    = first_q;
		kind_d     = kind_q;
		lenh_d     = lenh_q;
		rem_d      = rem_q;
		ev         = '0;
		ev.kind    = EV_SYMBOL_CHAR;
		creq       = '0;
		creq.kind  = kind_q;
		if (end_of_stream) begin
			ev.emit    = 1'b1;
			ev.kind    = EV_SUMMARY;
			creq.clear = 1'b1;
			phase_d    = PH_HDR0;
			first_d    = '0;
			kind_d     = KIND_SYM;
			lenh_d     = '0;
			rem_d      = '0;
		end else begin
			unique case (phase_q)
				PH_HDR0: begin
					first_d = data_byte;
					phase_d = PH_HDR1;
				end
				PH_HDR1: begin
					priority if (first_q == HDR_SYM_0 && data_byte == HDR_SYM_1)
						kind_d = KIND_SYM;
					else if (first_q == HDR_CODE_0 && data_byte == HDR_CODE_1)
						kind_d = KIND_CODE;
					else if (first_q == HDR_DATA_0 && data_byte == HDR_DATA_1)
						kind_d = KIND_DATA;
					else
						kind_d = KIND_UNK;
					phase_d = PH_ADR0;
				end
				PH_ADR0: phase_d = PH_ADR1;
				PH_ADR1: phase_d = PH_LENH;
				PH_LENH: begin
					lenh_d  = data_byte;
					phase_d = PH_LENL;
				end
				PH_LENL: begin
					if (kind_q == KIND_SYM)
						rem_d = {1'b0, n};
					else
						rem_d = {n, 1'b0};
					if (n == '0) begin
						creq.inc = 1'b1;
						phase_d  = PH_HDR0;
					end else begin
						phase_d  = PH_BODY;
					end
					if (kind_q == KIND_SYM && n == '0) begin
						ev.emit = 1'b1;
						ev.kind = EV_EMPTY_SYMBOL;
					end else if (kind_q == KIND_UNK) begin
						ev.emit = 1'b1;
						ev.kind = EV_UNKNOWN_HDR;
					end
				end
				PH_BODY: begin
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						creq.inc = 1'b1;
						phase_d  = PH_HDR0;
					end
					if (kind_q == KIND_SYM) begin
						ev.emit = 1'b1;
						ev.kind = EV_SYMBOL_CHAR;
						ev.ch   = data_byte;
						ev.last = (rem_dec == '0);
					end
				end
				default: phase_d = PH_HDR0;
			endcase
		end
		if (!step)
			creq = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			first_q <= '0;
			kind_q  <= KIND_SYM;
			lenh_q  <= '0;
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			first_q <= first_d;
			kind_q  <= kind_d;
			lenh_q  <= lenh_d;
			rem_q   <= rem_d;
		end
	end

endmodule

### design/ofsp_counters.sv
// Saturating section counters for code, data and symbol sections.
module ofsp_counters #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ofsp_pkg::count_req_t   creq,
	output logic [COUNT_WIDTH-1:0] code_cnt,
	output logic [COUNT_WIDTH-1:0] data_cnt,
	output logic [COUNT_WIDTH-1:0] sym_cnt
);
	import ofsp_pkg::*;

	logic [COUNT_WIDTH-1:0] code_q, data_q, sym_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			data_q <= '0;
			sym_q  <= '0;
		end else if (creq.clear) begin
			code_q <= '0;
			data_q <= '0;
			sym_q  <= '0;
		end else if (creq.inc) begin
			unique case (creq.kind)
				KIND_SYM:  if (sym_q != '1) sym_q <= sym_q + COUNT_WIDTH'(1);
				KIND_CODE: if (code_q != '1) code_q <= code_q + COUNT_WIDTH'(1);
				KIND_DATA: if (data_q != '1) data_q <= data_q + COUNT_WIDTH'(1);
				default: ;
			endcase
		end
	end

	assign code_cnt = code_q;
	assign data_cnt = data_q;
	assign sym_cnt  = sym_q;

endmodule

### design/object_file_section_parser_core.sv
// Object file section parser: takes one file byte per transfer and reports
// symbol characters, empty symbols, unknown headers and a summary of counts.
// The input channel (data_valid, data_ready) carries one byte or an
// end-of-stream mark per transfer; the result channel (result_valid,
// result_ready) carries at most one event per input byte.
// Each byte is held in an input register while the section phase logic
// works on it, and its event is registered in the result register when the
// byte leaves the input register.
// With result_ready held high one byte is taken every cycle.
// When the receiver stalls, the input register still takes one byte; bytes
// that raise no event keep flowing, and data_ready drops only when a byte
// that raises an event meets a full result register.
// An end-of-stream transfer gives the summary of saturating counts and
// returns the parser to its start state.
// Reset clears the phase, the counters and both valid flags at once.
module object_file_section_parser_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  event_kind,
	output logic [7:0]  symbol_char,
	output logic        string_end,
	output logic [15:0] code_sections,
	output logic [15:0] data_sections,
	output logic [15:0] symbol_sections
);
	import ofsp_pkg::*;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   eos_s1;
	logic                   advance;
	event_t                 ev;
	count_req_t             creq;
	logic [COUNT_WIDTH-1:0] code_cnt, data_cnt, sym_cnt;
	logic [COUNT_WIDTH+15:0] code_ext, data_ext, sym_ext;
	logic                   is_summary;

	assign advance    = valid_s1 && (!result_valid || result_ready || !ev.emit);
	assign data_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_valid && data_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			byte_s1 <= data_byte;
			eos_s1  <= end_of_stream;
		end
	end

	ofsp_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.data_byte     (byte_s1),
		.end_of_stream (eos_s1),
		.ev            (ev),
		.creq          (creq)
	);

	ofsp_counters #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_counters (
		.clk      (clk),
		.arst_n   (arst_n),
		.creq     (creq),
		.code_cnt (code_cnt),
		.data_cnt (data_cnt),
		.sym_cnt  (sym_cnt)
	);

	assign code_ext   = {16'b0, code_cnt};
	assign data_ext   = {16'b0, data_cnt};
	assign sym_ext    = {16'b0, sym_cnt};
	assign is_summary = (ev.kind == EV_SUMMARY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && ev.emit) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ev.emit) begin
			event_kind      <= ev.kind;
			symbol_char     <= ev.ch;
			string_end      <= ev.last;
			code_sections   <= is_summary ? code_ext[15:0] : 16'b0;
			data_sections   <= is_summary ? data_ext[15:0] : 16'b0;
			symbol_sections <= is_summary ? sym_ext[15:0] : 16'b0;
		end
	end

endmodule

### design/ofsp_checker.sv
// Port-level checks for the object file section parser, bound to the top level.
module ofsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        data_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  event_kind,
	input logic [7:0]  symbol_char,
	input logic        string_end,
	input logic [15:0] code_sections,
	input logic [15:0] data_sections,
	input logic [15:0] symbol_sections
);
	import ofsp_pkg::*;

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(event_kind)
			&& $stable(symbol_char) && $stable(string_end))
		else $error("result changed or vanished while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!data_ready |-> result_valid && !result_ready)
		else $error("input stalled without a stalled result");

	a_char_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && event_kind != EV_SYMBOL_CHAR |-> symbol_char == 8'd0
			&& !string_end)
		else $error("character fields set on a non-character event");

	a_count_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && event_kind != EV_SUMMARY |-> code_sections == 16'd0
			&& data_sections == 16'd0 && symbol_sections == 16'd0)
		else $error("count fields set on a non-summary event");

endmodule

bind object_file_section_parser_core ofsp_checker u_ofsp_checker (.*);

### bench/testbench.sv
// Self-checking testbench for the object file section parser core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ofsp_pkg::*;

	localparam int CNT_W = 16;
	localparam int CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  ch;
		logic        last;
		logic [15:0] code;
		logic [15:0] data;
		logic [15:0] sym;
	} parsed_event_t;

	class section_scoreboard;
		phase_t            phase;
		logic [7:0]        hdr_first;
		section_kind_t     kind;
		logic [7:0]        len_high;
		logic [16:0]       body_left;
		logic [CNT_W-1:0]  code_count;
		logic [CNT_W-1:0]  data_count;
		logic [CNT_W-1:0]  sym_count;
		parsed_event_t     awaited[$];
		int                errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			phase = PH_HDR0;
			hdr_first = '0;
			kind = KIND_SYM;
			len_high = '0;
			body_left = '0;
			code_count = '0;
			data_count = '0;
			sym_count = '0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void count_done();
			case (kind)
				KIND_SYM: if (sym_count != '1) sym_count++;
				KIND_CODE: if (code_count != '1) code_count++;
				KIND_DATA: if (data_count != '1) data_count++;
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic eos);
			parsed_event_t ev;
			logic [15:0] n;
			ev = '0;
			if (eos) begin
				ev.kind = EV_SUMMARY;
				ev.code = 16'(code_count);
				ev.data = 16'(data_count);
				ev.sym = 16'(sym_count);
				awaited.push_back(ev);
				restart();
				return;
			end
			case (phase)
				PH_HDR0: begin
					hdr_first = b;
					phase = PH_HDR1;
				end
				PH_HDR1: begin
					if (hdr_first == HDR_SYM_0 && b == HDR_SYM_1)
						kind = KIND_SYM;
					else if (hdr_first == HDR_CODE_0 && b == HDR_CODE_1)
						kind = KIND_CODE;
					else if (hdr_first == HDR_DATA_0 && b == HDR_DATA_1)
						kind = KIND_DATA;
					else
						kind = KIND_UNK;
					phase = PH_ADR0;
				end
				PH_ADR0: phase = PH_ADR1;
				PH_ADR1: phase = PH_LENH;
				PH_LENH: begin
					len_high = b;
					phase = PH_LENL;
				end
				PH_LENL: begin
					n = {len_high, b};
					body_left = (kind == KIND_SYM) ? 17'(n) : {n, 1'b0};
					if (n == 0) begin
						count_done();
						phase = PH_HDR0;
					end else begin
						phase = PH_BODY;
					end
					if (kind == KIND_SYM && n == 0) begin
						ev.kind = EV_EMPTY_SYMBOL;
						awaited.push_back(ev);
					end else if (kind == KIND_UNK) begin
						ev.kind = EV_UNKNOWN_HDR;
						awaited.push_back(ev);
					end
				end
				PH_BODY: begin
					if (body_left != 0)
						body_left--;
					if (body_left == 0) begin
						count_done();
						phase = PH_HDR0;
					end
					if (kind == KIND_SYM) begin
						ev.kind = EV_SYMBOL_CHAR;
						ev.ch = b;
						ev.last = (body_left == 0);
						awaited.push_back(ev);
					end
				end
				default: phase = PH_HDR0;
			endcase
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_event(logic [1:0] k, logic [7:0] c, logic l,
				logic [15:0] cc, logic [15:0] dc, logic [15:0] sc);
			parsed_event_t w;
			if (awaited.size() == 0) begin
				report($sformatf("event of kind %0d with none outstanding", k));
				return;
			end
			w = awaited.pop_front();
			if (k !== w.kind)
				report($sformatf("event_kind %0d, wanted %0d", k, w.kind));
			if (c !== w.ch)
				report($sformatf("symbol_char %h, wanted %h", c, w.ch));
			if (l !== w.last)
				report($sformatf("string_end %b, wanted %b", l, w.last));
			if (cc !== w.code)
				report($sformatf("code_sections %0d, wanted %0d", cc, w.code));
			if (dc !== w.data)
				report($sformatf("data_sections %0d, wanted %0d", dc, w.data));
			if (sc !== w.sym)
				report($sformatf("symbol_sections %0d, wanted %0d", sc, w.sym));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        data_valid;
	logic        data_ready;
	logic [7:0]  data_byte;
	logic        end_of_stream;
	logic        result_valid;
	logic        result_ready;
	logic [1:0]  event_kind;
	logic [7:0]  symbol_char;
	logic        string_end;
	logic [15:0] code_sections;
	logic [15:0] data_sections;
	logic [15:0] symbol_sections;

	section_scoreboard sb;
	int send_gap_pct;
	int stall_pct;
	int items_sent;
	int cycles;

	object_file_section_parser_core #(
		.COUNT_WIDTH(CNT_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_ready(data_ready),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.event_kind(event_kind),
		.symbol_char(symbol_char),
		.string_end(string_end),
		.code_sections(code_sections),
		.data_sections(data_sections),
		.symbol_sections(symbol_sections)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Results are checked before the input of the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				sb.check_event(event_kind, symbol_char, string_end,
					code_sections, data_sections, symbol_sections);
			if (data_valid && data_ready)
				sb.note_byte(data_byte, end_of_stream);
		end
	end

	task automatic send(input logic [7:0] b, input logic eos);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		do @(posedge clk); while (!data_ready);
		items_sent++;
	endtask

	task automatic send_header(input logic [7:0] h0, input logic [7:0] h1,
			input logic [15:0] addr, input logic [15:0] n);
		send(h0, 1'b0);
		send(h1, 1'b0);
		send(addr[15:8], 1'b0);
		send(addr[7:0], 1'b0);
		send(n[15:8], 1'b0);
		send(n[7:0], 1'b0);
	endtask

	task automatic hold_until_drained();
		data_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic random_section();
		logic [7:0]  h0;
		logic [7:0]  h1;
		logic [15:0] n;
		int          pick;
		int          body;
		bit          cut_short;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			h0 = HDR_SYM_0;
			h1 = HDR_SYM_1;
		end else if (pick < 55) begin
			h0 = HDR_CODE_0;
			h1 = HDR_CODE_1;
		end else if (pick < 75) begin
			h0 = HDR_DATA_0;
			h1 = HDR_DATA_1;
		end else begin
			case ($urandom_range(0, 3))
				0: h0 = HDR_SYM_0;
				1: h0 = HDR_CODE_0;
				2: h0 = HDR_DATA_0;
				default: h0 = 8'($urandom);
			endcase
			h1 = 8'($urandom);
		end
		pick = $urandom_range(0, 99);
		cut_short = 1'b0;
		if (pick < 4) begin
			n = 16'($urandom);
			cut_short = 1'b1;
		end else if (pick < 6) begin
			n = 16'($urandom_range(200, 300));
		end else if (pick < 66) begin
			n = 16'($urandom_range(0, 3));
		end else begin
			n = 16'($urandom_range(4, 20));
		end
		send_header(h0, h1, 16'($urandom), n);
		body = (h0 == HDR_SYM_0 && h1 == HDR_SYM_1) ? int'(n) : 2 * int'(n);
		if (cut_short && body > 0)
			body = $urandom_range(0, (body < 12) ? body - 1 : 12);
		repeat (body) send(8'($urandom), 1'b0);
		if (cut_short)
			send(8'($urandom), 1'b1);
	endtask

	task automatic random_stream(input int count);
		int goal;
		int pick;
		goal = items_sent + count;
		while (items_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 6)
				send(8'($urandom), 1'b1);
			else if (pick < 12)
				send(8'($urandom), 1'b0);
			else
				random_section();
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		items_sent = 0;
		send_gap_pct = 25;
		stall_pct = 52;
		arst_n <= 1'b0;
		data_valid <= 1'b0;
		data_byte <= 8'h00;
		end_of_stream <= 1'b0;
		result_ready <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_header(HDR_SYM_0, HDR_SYM_1, 16'hFFFF, 16'd1);
		send(8'hFF, 1'b0);
		send_header(HDR_DATA_0, HDR_DATA_1, 16'h0000, 16'd0);
		send_header(HDR_SYM_0, HDR_SYM_1, 16'h8001, 16'd0);
		send_header(HDR_CODE_0, 8'h00, 16'h5AA5, 16'd1);
		send(8'hA5, 1'b1);
		hold_until_drained();

		random_stream(230);
		send_gap_pct = 52;
		stall_pct = 25;
		random_stream(230);
		send_gap_pct = 0;
		stall_pct = 0;
		random_stream(240);

		send_header(HDR_DATA_0, HDR_DATA_1, 16'h1234, 16'd0);
		send(8'($urandom), 1'b1);

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d events never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
